// ===== rtl/core/stkpp_pkg.sv =====
// Shared constants and control types for the spectral top-k peak picker.
package stkpp_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int MAX_BINS  = 4096;

   localparam int AMP_W   = 32;
   localparam int FREQ_W  = 44;
   localparam int START_W = 12;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int BIN_W  = $clog2(MAX_BINS + 1);
   localparam int CMP_W  = (BIN_W > START_W + 1) ? BIN_W : START_W + 1;
   localparam int PROD_W = BIN_W + AMP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_AMP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INDEX   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_STEP     = 2'd2;

   localparam logic [AMP_W-1:0] FREQ_STEP_RESET = 32'd65536;

   typedef struct packed {
      logic accept;
      logic fill;
      logic scan_start;
      logic scan_step;
      logic replace;
      logic emit_load;
   } ctrl_type;

   typedef struct packed {
      logic peak;
      logic last;
      logic full;
      logic k_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/stkpp_ctrl.sv =====
// Controller state machine for the spectral top-k peak picker.
module stkpp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stkpp_pkg::status_type status,
   output stkpp_pkg::ctrl_type   ctrl
);
   import stkpp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECORD,
      ST_SCAN,
      ST_REPLACE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.accept = 1'b1;
               state_in    = ST_RECORD;
            end
         end
         ST_RECORD: begin
            if (status.peak && status.full) begin
               ctrl.scan_start = 1'b1;
               state_in        = ST_SCAN;
            end else begin
               ctrl.fill = status.peak;
               state_in  = status.last ? ST_EMIT : ST_IDLE;
            end
         end
         ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (status.k_last) begin
               state_in = ST_REPLACE;
            end
         end
         ST_REPLACE: begin
            ctrl.replace = 1'b1;
            state_in     = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            ctrl.emit_load = status.out_free;
            if (status.out_free && status.k_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/stkpp_dp.sv =====
// Datapath of the spectral top-k peak picker: registers, peak test, slots and result stage.
module stkpp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [stkpp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stkpp_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [stkpp_pkg::AMP_W-1:0]          req_bin_amp,
   input  logic                                 req_final_bin,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_slot_index,
   output logic                                 rsp_slot_used,
   output logic [stkpp_pkg::FREQ_W-1:0]         rsp_peak_freq,
   output logic [stkpp_pkg::AMP_W-1:0]          rsp_peak_amp,
   output logic [3:0]                           rsp_peaks_found,
   output logic                                 rsp_last_slot,
   input  stkpp_pkg::ctrl_type                  ctrl,
   output stkpp_pkg::status_type                status
);
   import stkpp_pkg::*;

   logic [AMP_W-1:0]   thresh_ff;
   logic [START_W-1:0] start_ff;
   logic [AMP_W-1:0]   step_ff;

   logic [AMP_W-1:0]  older_ff,  older_in;
   logic [AMP_W-1:0]  middle_ff, middle_in;
   logic [BIN_W-1:0]  bin_cnt_ff, bin_cnt_in;
   logic [CNT_W-1:0]  filled_ff, filled_in;
   logic              last_ff;
   logic              peak_ff;
   logic [AMP_W-1:0]  cand_amp_ff;
   logic [FREQ_W-1:0] cand_freq_ff;
   logic [SLOT_W-1:0] k_ff, k_in;
   logic [SLOT_W-1:0] weak_idx_ff;
   logic [AMP_W-1:0]  weak_amp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [AMP_W-1:0]  slot_amp_ff  [NUM_SLOTS];
   logic [FREQ_W-1:0] slot_freq_ff [NUM_SLOTS];

   logic [2:0]        out_index_ff;
   logic              out_used_ff;
   logic [FREQ_W-1:0] out_freq_ff;
   logic [AMP_W-1:0]  out_amp_ff;
   logic [3:0]        out_found_ff;
   logic              out_last_ff;

   logic              peak_in;
   logic [PROD_W-1:0] prod;
   logic [CMP_W-1:0]  bin_wide;
   logic [CMP_W-1:0]  start_wide;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_idx;
   logic [AMP_W-1:0]  rd_amp;
   logic [FREQ_W-1:0] rd_freq;
   logic              rd_used;
   logic              spectrum_done;

   // Bin m = counter - 1 is tested when bin m + 1 arrives.
   always_comb begin
      bin_wide   = CMP_W'(bin_cnt_ff);
      start_wide = CMP_W'(start_ff) + CMP_W'(1);
      peak_in    = (bin_cnt_ff != BIN_W'(MAX_BINS)) && (bin_wide > start_wide) &&
                   (middle_ff > thresh_ff) && (middle_ff > older_ff) &&
                   (middle_ff > req_bin_amp);
      prod       = PROD_W'(bin_cnt_ff) * PROD_W'(step_ff);
   end

   assign rd_amp  = slot_amp_ff[k_ff];
   assign rd_freq = slot_freq_ff[k_ff];
   assign rd_used = CNT_W'(k_ff) < filled_ff;

   assign status.peak     = peak_ff;
   assign status.last     = last_ff;
   assign status.full     = (filled_ff == CNT_W'(NUM_SLOTS));
   assign status.k_last   = (k_ff == SLOT_W'(NUM_SLOTS - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign spectrum_done = ctrl.emit_load && status.k_last;

   always_comb begin
      wr_en  = 1'b0;
      wr_idx = weak_idx_ff;
      if (ctrl.fill) begin
         wr_en  = 1'b1;
         wr_idx = filled_ff[SLOT_W-1:0];
      end else if (ctrl.replace && (cand_amp_ff > weak_amp_ff)) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      older_in     = older_ff;
      middle_in    = middle_ff;
      bin_cnt_in   = bin_cnt_ff;
      filled_in    = filled_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.accept) begin
         older_in  = middle_ff;
         middle_in = req_bin_amp;
         k_in      = '0;
         if (bin_cnt_ff != BIN_W'(MAX_BINS)) begin
            bin_cnt_in = bin_cnt_ff + BIN_W'(1);
         end
      end
      if (ctrl.fill) begin
         filled_in = filled_ff + CNT_W'(1);
      end
      if (ctrl.scan_start) begin
         k_in = SLOT_W'(1);
      end
      if (ctrl.scan_step) begin
         k_in = k_ff + SLOT_W'(1);
      end
      if (ctrl.replace) begin
         k_in = '0;
      end
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit_load) begin
         rsp_valid_in = 1'b1;
         k_in         = k_ff + SLOT_W'(1);
      end
      if (spectrum_done) begin
         older_in   = '0;
         middle_in  = '0;
         bin_cnt_in = '0;
         filled_in  = '0;
         k_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= '0;
         start_ff     <= '0;
         step_ff      <= FREQ_STEP_RESET;
         older_ff     <= '0;
         middle_ff    <= '0;
         bin_cnt_ff   <= '0;
         filled_ff    <= '0;
         k_ff         <= '0;
         peak_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_AMP_THRESHOLD: thresh_ff <= csr_wdata[AMP_W-1:0];
               CSR_START_INDEX:   start_ff  <= csr_wdata[START_W-1:0];
               CSR_FREQ_STEP:     step_ff   <= csr_wdata[AMP_W-1:0];
               default:           ;
            endcase
         end
         older_ff     <= older_in;
         middle_ff    <= middle_in;
         bin_cnt_ff   <= bin_cnt_in;
         filled_ff    <= filled_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.accept) begin
            peak_ff <= peak_in;
            last_ff <= req_final_bin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cand_amp_ff  <= middle_ff;
         cand_freq_ff <= FREQ_W'(prod);
      end
      if (ctrl.scan_start) begin
         weak_idx_ff <= '0;
         weak_amp_ff <= slot_amp_ff[0];
      end else if (ctrl.scan_step && (rd_amp < weak_amp_ff)) begin
         weak_idx_ff <= k_ff;
         weak_amp_ff <= rd_amp;
      end
      if (wr_en) begin
         slot_amp_ff[wr_idx]  <= cand_amp_ff;
         slot_freq_ff[wr_idx] <= cand_freq_ff;
      end
      if (ctrl.emit_load) begin
         out_index_ff <= 3'(k_ff);
         out_used_ff  <= rd_used;
         out_freq_ff  <= rd_used ? rd_freq : '0;
         out_amp_ff   <= rd_used ? rd_amp : '0;
         out_found_ff <= 4'(filled_ff);
         out_last_ff  <= status.k_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = out_index_ff;
   assign rsp_slot_used   = out_used_ff;
   assign rsp_peak_freq   = out_freq_ff;
   assign rsp_peak_amp    = out_amp_ff;
   assign rsp_peaks_found = out_found_ff;
   assign rsp_last_slot   = out_last_ff;

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(NUM_SLOTS))
      else $error("slot fill count exceeds the number of slots");

   a_fill_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.fill |-> !status.full)
      else $error("slot filled while all slots are in use");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      spectrum_done |=> (filled_ff == '0) && (bin_cnt_ff == '0))
      else $error("spectrum state not cleared after the last result");

   a_replace_after_scan: assert property (@(posedge clock) disable iff (reset)
      ctrl.replace |-> $past(ctrl.scan_step))
      else $error("slot replacement without a preceding weakest-slot scan");

endmodule

// ===== rtl/core/spectral_top_k_peak_picker.sv =====
// Top level of the spectral top-k peak picker: controller and datapath.
// An item without a replacement passes through the idle and record states; a peak
// found when all slots are full adds the one-slot-per-cycle scan for the weakest slot
// and a replace step. The final bin of a spectrum adds a result phase over all 8 slots,
// one slot read per cycle, held while the result side stalls.
// Synchronous active-high reset clears the spectrum state and loads register defaults.
module spectral_top_k_peak_picker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [stkpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stkpp_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [stkpp_pkg::AMP_W-1:0]      req_bin_amp,
   input  logic                             req_final_bin,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_slot_index,
   output logic                             rsp_slot_used,
   output logic [stkpp_pkg::FREQ_W-1:0]     rsp_peak_freq,
   output logic [stkpp_pkg::AMP_W-1:0]      rsp_peak_amp,
   output logic [3:0]                       rsp_peaks_found,
   output logic                             rsp_last_slot
);
   import stkpp_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   stkpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   stkpp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_bin_amp     (req_bin_amp),
      .req_final_bin   (req_final_bin),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_slot_used   (rsp_slot_used),
      .rsp_peak_freq   (rsp_peak_freq),
      .rsp_peak_amp    (rsp_peak_amp),
      .rsp_peaks_found (rsp_peaks_found),
      .rsp_last_slot   (rsp_last_slot),
      .ctrl            (ctrl),
      .status          (status)
   );

endmodule
